// ===== hw/rtl/lsu_pkg.sv =====
// ----------------------------------------------------------------------------
// lsu_pkg
// Shared types and constants of the logic and shift unit.
// ----------------------------------------------------------------------------
package lsu_pkg;

    // Size of the byte register file and the width of its address.
    localparam int unsigned REG_COUNT  = 32;
    localparam int unsigned REG_ADDR_W = $clog2(REG_COUNT);

    // Fixed field widths.
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned INDEX_W = 5;
    localparam int unsigned OP_W    = 4;

    localparam logic [DATA_W-1:0] BYTE_ALL_ONES = 8'hFF;
    localparam logic [DATA_W-1:0] BYTE_ZERO     = 8'h00;
    localparam int unsigned       SIGN_POS      = DATA_W - 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_AND  = 4'd0;
    localparam logic [OP_W-1:0] OP_ANDI = 4'd1;
    localparam logic [OP_W-1:0] OP_OR   = 4'd2;
    localparam logic [OP_W-1:0] OP_ORI  = 4'd3;
    localparam logic [OP_W-1:0] OP_EOR  = 4'd4;
    localparam logic [OP_W-1:0] OP_COM  = 4'd5;
    localparam logic [OP_W-1:0] OP_SER  = 4'd6;
    localparam logic [OP_W-1:0] OP_CLR  = 4'd7;
    localparam logic [OP_W-1:0] OP_LSR  = 4'd8;
    localparam logic [OP_W-1:0] OP_ROR  = 4'd9;

    typedef logic [DATA_W-1:0]     byte_t;
    typedef logic [REG_ADDR_W-1:0] reg_addr_t;

    // Status flags.
    typedef struct packed {
        logic s;
        logic v;
        logic n;
        logic z;
        logic c;
    } flags_t;

    // What the execute logic hands back for one instruction.
    typedef struct packed {
        byte_t  value;
        flags_t flags;
        logic   wr_en;
    } alu_out_t;

endpackage

// ===== hw/rtl/lsu_ram.sv =====
// ----------------------------------------------------------------------------
// lsu_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lsu_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

// ===== hw/rtl/lsu_alu.sv =====
// ----------------------------------------------------------------------------
// lsu_alu
// Combinational execute logic: result byte, new flags and write enable.
// ----------------------------------------------------------------------------
module lsu_alu (
    input  logic [3:0]       op,
    input  lsu_pkg::byte_t   opnd_a,
    input  lsu_pkg::byte_t   opnd_b,
    input  lsu_pkg::byte_t   immediate,
    input  lsu_pkg::flags_t  flags_in,
    output lsu_pkg::alu_out_t res
);
    import lsu_pkg::*;

    byte_t value;
    logic  carry;
    logic  is_shift;
    logic  update;
    logic  known;
    logic  n_bit;
    logic  v_bit;

    always_comb
    begin
        value    = BYTE_ZERO;
        carry    = flags_in.c;
        is_shift = 1'b0;
        update   = 1'b1;
        known    = 1'b1;
        unique case (op)
            OP_AND:  value = opnd_a & opnd_b;
            OP_ANDI: value = opnd_a & immediate;
            OP_OR:   value = opnd_a | opnd_b;
            OP_ORI:  value = opnd_a | immediate;
            OP_EOR:  value = opnd_a ^ opnd_b;
            OP_COM:
            begin
                value = opnd_a ^ BYTE_ALL_ONES;
                carry = 1'b1;
            end
            OP_SER:
            begin
                value  = BYTE_ALL_ONES;
                update = 1'b0;
            end
            OP_CLR:  value = BYTE_ZERO;
            OP_LSR:
            begin
                value    = {1'b0, opnd_a[DATA_W-1:1]};
                carry    = opnd_a[0];
                is_shift = 1'b1;
            end
            OP_ROR:
            begin
                value    = {flags_in.c, opnd_a[DATA_W-1:1]};
                carry    = opnd_a[0];
                is_shift = 1'b1;
            end
            default:
            begin
                update = 1'b0;
                known  = 1'b0;
            end
        endcase
    end

    assign n_bit = value[SIGN_POS];
    assign v_bit = is_shift & (n_bit ^ carry);

    always_comb
    begin
        res.value = value;
        res.wr_en = known;
        if (update)
        begin
            res.flags.c = carry;
            res.flags.z = (value == BYTE_ZERO);
            res.flags.n = n_bit;
            res.flags.v = v_bit;
            res.flags.s = n_bit ^ v_bit;
        end
        else
        begin
            res.flags = flags_in;
        end
    end

endmodule

// ===== hw/rtl/logic_shift_unit_with_flags_top.sv =====
// ----------------------------------------------------------------------------
// logic_shift_unit_with_flags_top
// Eight-bit logic and shift unit with a byte register file and status flags.
// ----------------------------------------------------------------------------
// Each input transfer carries one instruction (AND, ANDI, OR, ORI, EOR, COM,
// SER, CLR, LSR or ROR) that reads the destination register and, for AND, OR
// and EOR, a source register, writes the destination and, but for SER,
// updates the C, Z, N, V and S flags; each instruction yields exactly one
// output transfer with the byte written and the flags after it. The unit
// sustains one instruction per clock while the output is accepted: an
// instruction passes from the operand stage, where the register file read data
// arrives, into the result register. Back-to-back dependent instructions run
// at full rate because the most recent register write is forwarded to the
// operand stage. The register file is a RAM whose entries carry valid bits
// cleared at reset, so it reads as zero from the first cycle without a
// clearing pass. Unused operation codes write nothing, report a zero byte
// and leave the flags untouched.
// ----------------------------------------------------------------------------
module logic_shift_unit_with_flags_top (
    input  logic clk,
    input  logic rst_n,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] op,
    input  logic [4:0] dest_index,
    input  logic [4:0] src_index,
    input  logic [7:0] immediate,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] result_value,
    output logic       carry_flag,
    output logic       zero_flag,
    output logic       negative_flag,
    output logic       overflow_flag,
    output logic       sign_flag
);
    import lsu_pkg::*;

    // Handshake and stage control.
    logic      in_fire;
    logic      s1_advance;
    logic      dest_ok;
    logic      src_ok;
    reg_addr_t dest_addr;
    reg_addr_t src_addr;

    // Operand stage.
    logic        s1_valid_reg;
    logic [3:0]  s1_op_reg;
    reg_addr_t   s1_dest_reg;
    reg_addr_t   s1_src_reg;
    logic        s1_dest_ok_reg;
    logic        s1_src_ok_reg;
    logic        s1_a_live_reg;
    logic        s1_b_live_reg;
    byte_t       s1_imm_reg;

    // Register file, valid bits and write forwarding.
    logic [REG_COUNT-1:0] valid_reg;
    byte_t     ram_a;
    byte_t     ram_b;
    logic      wr_en;
    logic      fwd_valid_reg;
    reg_addr_t fwd_addr_reg;
    byte_t     fwd_data_reg;

    // Execute and result stage.
    byte_t    opnd_a;
    byte_t    opnd_b;
    flags_t   flags_reg;
    alu_out_t alu_res;
    logic     out_valid_reg;
    byte_t    out_value_reg;
    flags_t   out_flags_reg;

    assign dest_ok   = 32'(dest_index) < REG_COUNT;
    assign src_ok    = 32'(src_index) < REG_COUNT;
    assign dest_addr = dest_index[REG_ADDR_W-1:0];
    assign src_addr  = src_index[REG_ADDR_W-1:0];

    // The operand stage moves on whenever the result register is free or
    // is being emptied in this cycle; a new instruction enters as it leaves.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // Registers are written as the instruction passes into the result
    // register; a write to an index beyond the file is dropped.
    assign wr_en = s1_advance && alu_res.wr_en && s1_dest_ok_reg;

    lsu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (s1_dest_reg),
        .wr_data   (alu_res.value),
        .rd_en     (in_fire),
        .rd_addr_a (dest_addr),
        .rd_addr_b (src_addr),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    // The RAM read can happen at the same edge as the write of the preceding
    // instruction, so that write is taken from the forwarding register.
    // Entries never written since reset read as zero.
    always_comb
    begin
        if (fwd_valid_reg && s1_dest_ok_reg && (fwd_addr_reg == s1_dest_reg))
        begin
            opnd_a = fwd_data_reg;
        end
        else
        begin
            opnd_a = s1_a_live_reg ? ram_a : BYTE_ZERO;
        end
        if (fwd_valid_reg && s1_src_ok_reg && (fwd_addr_reg == s1_src_reg))
        begin
            opnd_b = fwd_data_reg;
        end
        else
        begin
            opnd_b = s1_b_live_reg ? ram_b : BYTE_ZERO;
        end
    end

    lsu_alu u_alu (
        .op        (s1_op_reg),
        .opnd_a    (opnd_a),
        .opnd_b    (opnd_b),
        .immediate (s1_imm_reg),
        .flags_in  (flags_reg),
        .res       (alu_res)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            valid_reg     <= '0;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= alu_res.flags;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                fwd_valid_reg          <= 1'b1;
                valid_reg[s1_dest_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg      <= op;
            s1_dest_reg    <= dest_addr;
            s1_src_reg     <= src_addr;
            s1_dest_ok_reg <= dest_ok;
            s1_src_ok_reg  <= src_ok;
            s1_a_live_reg  <= dest_ok && valid_reg[dest_addr];
            s1_b_live_reg  <= src_ok && valid_reg[src_addr];
            s1_imm_reg     <= immediate;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_dest_reg;
            fwd_data_reg <= alu_res.value;
        end
        if (s1_advance)
        begin
            out_value_reg <= alu_res.value;
            out_flags_reg <= alu_res.flags;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = out_value_reg;
    assign carry_flag    = out_flags_reg.c;
    assign zero_flag     = out_flags_reg.z;
    assign negative_flag = out_flags_reg.n;
    assign overflow_flag = out_flags_reg.v;
    assign sign_flag     = out_flags_reg.s;

    // An empty operand stage must always take a new instruction.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("operand stage empty but input not ready");

    // An instruction leaving the operand stage is presented at the output.
    a_advance_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid)
        else $error("executed instruction missing at output");

    // A committed write marks its register as written.
    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(s1_dest_reg)] && fwd_valid_reg)
        else $error("register write not recorded");

    // S is always N xor V in the architectural flags.
    a_sign_rule: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.s == (flags_reg.n ^ flags_reg.v))
        else $error("sign flag inconsistent");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eight-bit logic and shift unit.
// ----------------------------------------------------------------------------
// Instructions are offered on the input channel with random idle gaps, and
// results are taken on the output channel under a randomly stalling ready.
// A scoreboard keeps its own copy of the register file and the status flags,
// works out the byte and the flags that every accepted instruction must
// give, and compares each result transfer with the oldest outstanding
// prediction. A directed opening covers every operation, the operand
// extremes and the corner cases; a long random part follows, built around
// register reuse so that dependent instructions meet back to back.
// ----------------------------------------------------------------------------
module tb_top;

    import lsu_pkg::*;

    // Operation codes outside the defined set: the unit must ignore these.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_ROR + 1'b1;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_ITEMS    = 700;
    localparam int HOLD_OFF_AT     = 250;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 8;
    // The limit leaves a wide margin over the slowest legal run.
    localparam int CYCLE_LIMIT     = 200000;

    // One predicted result: the byte written and the flags after it.
    typedef struct packed {
        byte_t  value;
        flags_t flags;
    } lsu_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard. It mirrors the architectural state of the unit and holds
    // the results still owed by it, oldest first.
    // ------------------------------------------------------------------------
    class lsu_scoreboard;
        byte_t       reg_mirror [REG_COUNT];
        flags_t      status;
        lsu_result_t owed_results [$];
        int          mismatches;
        int          results_seen;

        function new();
            foreach (reg_mirror[i])
                reg_mirror[i] = BYTE_ZERO;
            status       = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Registers beyond the file read as zero.
        function byte_t read_reg(logic [INDEX_W-1:0] idx);
            if (idx < REG_COUNT)
                return reg_mirror[idx];
            return BYTE_ZERO;
        endfunction

        // Executes an accepted instruction on the mirror and queues the
        // result it must produce.
        function void note_instruction(logic [OP_W-1:0] op_code,
                                       logic [INDEX_W-1:0] dest,
                                       logic [INDEX_W-1:0] src,
                                       byte_t imm);
            byte_t       a;
            byte_t       b;
            byte_t       res;
            logic        carry;
            logic        is_shift;
            logic        writes;
            logic        touches_flags;
            lsu_result_t owed;

            a             = read_reg(dest);
            b             = read_reg(src);
            carry         = status.c;
            is_shift      = 1'b0;
            writes        = 1'b1;
            touches_flags = 1'b1;
            res           = BYTE_ZERO;

            case (op_code)
                OP_AND:  res = a & b;
                OP_ANDI: res = a & imm;
                OP_OR:   res = a | b;
                OP_ORI:  res = a | imm;
                OP_EOR:  res = a ^ b;
                OP_COM:
                begin
                    res   = ~a;
                    carry = 1'b1;
                end
                OP_SER:
                begin
                    res           = BYTE_ALL_ONES;
                    touches_flags = 1'b0;
                end
                OP_CLR:  res = BYTE_ZERO;
                OP_LSR:
                begin
                    res      = a >> 1;
                    carry    = a[0];
                    is_shift = 1'b1;
                end
                OP_ROR:
                begin
                    res      = {status.c, a[DATA_W-1:1]};
                    carry    = a[0];
                    is_shift = 1'b1;
                end
                default:
                begin
                    writes        = 1'b0;
                    touches_flags = 1'b0;
                end
            endcase

            if (touches_flags)
            begin
                status.c = carry;
                status.z = (res == BYTE_ZERO);
                status.n = res[SIGN_POS];
                status.v = is_shift ? (res[SIGN_POS] ^ carry) : 1'b0;
                status.s = status.n ^ status.v;
            end
            if (writes && dest < REG_COUNT)
                reg_mirror[dest] = res;

            owed.value = res;
            owed.flags = status;
            owed_results.push_back(owed);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] ERROR result %0d: %s", $realtime, results_seen, msg);
            mismatches++;
        endtask

        task check_field(string field, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
        endtask

        task check_result(byte_t value, flags_t flags);
            lsu_result_t owed;
            if (owed_results.size() == 0)
            begin
                report_mismatch("result transfer with no instruction outstanding");
            end
            else
            begin
                owed = owed_results.pop_front();
                check_field("result_value",  value,   owed.value);
                check_field("carry_flag",    flags.c, owed.flags.c);
                check_field("zero_flag",     flags.z, owed.flags.z);
                check_field("negative_flag", flags.n, owed.flags.n);
                check_field("overflow_flag", flags.v, owed.flags.v);
                check_field("sign_flag",     flags.s, owed.flags.s);
            end
            results_seen++;
        endtask

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the unit starts at a known value.
    // ------------------------------------------------------------------------
    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    op         = OP_AND;
    logic [INDEX_W-1:0] dest_index = '0;
    logic [INDEX_W-1:0] src_index  = '0;
    byte_t              immediate  = BYTE_ZERO;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    byte_t              result_value;
    logic               carry_flag;
    logic               zero_flag;
    logic               negative_flag;
    logic               overflow_flag;
    logic               sign_flag;

    logic               hold_off    = 1'b0;
    logic               quiet_phase = 1'b0;
    int                 items_sent  = 0;
    int                 cycle_count = 0;

    lsu_scoreboard      result_board = new();

    logic_shift_unit_with_flags_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .dest_index    (dest_index),
        .src_index     (src_index),
        .immediate     (immediate),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (result_value),
        .carry_flag    (carry_flag),
        .zero_flag     (zero_flag),
        .negative_flag (negative_flag),
        .overflow_flag (overflow_flag),
        .sign_flag     (sign_flag)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Idle lengths for both channels: idle_pct is the chance of a gap at all.
    // Most gaps are a few cycles, a few of them run much longer.
    // ------------------------------------------------------------------------
    function automatic int random_gap(int idle_pct);
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // ------------------------------------------------------------------------
    // Monitors. All stimulus changes at the rising edge, so the values seen
    // at the falling edge are exactly those that the next rising edge will
    // act upon. Sampling there keeps the checks free of any race with the
    // unit's own updates.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            result_board.note_instruction(op, dest_index, src_index, immediate);
            items_sent++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            result_board.check_result(result_value,
                                      '{s: sign_flag, v: overflow_flag,
                                        n: negative_flag, z: zero_flag,
                                        c: carry_flag});
    end

    // ------------------------------------------------------------------------
    // Receiver. Ready is withdrawn for random stretches, with runs of
    // unbroken readiness in between, and is forced low during the hold-off.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (free_left > 0)
                    free_left--;
                else if ($urandom_range(0, 99) < 5)
                    free_left = $urandom_range(20, 60);
                else
                    stall_left = random_gap(20);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Hold-off. Once the run is well under way the receiver refuses results
    // for a long stretch while the sender keeps offering instructions, so
    // that the pipeline fills and the unit has to stall its input.
    // ------------------------------------------------------------------------
    initial
    begin
        wait (items_sent >= HOLD_OFF_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Cycle limit: a run that hangs is ended here as a failure.
    // ------------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("logic_shift_unit_with_flags_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at the rising edge on which
    // the transfer takes place. Valid is only lowered when a gap follows,
    // so back-to-back instructions keep it high throughout.
    // ------------------------------------------------------------------------
    task automatic send_instruction(input logic [OP_W-1:0] op_code,
                                    input logic [INDEX_W-1:0] dest,
                                    input logic [INDEX_W-1:0] src,
                                    input byte_t imm);
        int gap;
        gap = (hold_off || quiet_phase) ? 0 : random_gap(40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op         <= op_code;
        dest_index <= dest;
        src_index  <= src;
        immediate  <= imm;
        in_valid   <= 1'b1;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    // Immediates lean towards the byte extremes and the sign bit.
    function automatic byte_t random_immediate();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return BYTE_ZERO;
        if (pick < 30)
            return BYTE_ALL_ONES;
        if (pick < 38)
            return byte_t'(1) << SIGN_POS;
        if (pick < 44)
            return byte_t'(1);
        return byte_t'($urandom_range(0, 255));
    endfunction

    // Random instructions. Register numbers are often reused from the last
    // instruction so that results are consumed at once by the next one.
    task automatic send_random_instructions(int count);
        logic [OP_W-1:0]    op_code;
        logic [INDEX_W-1:0] dest;
        logic [INDEX_W-1:0] src;
        logic [INDEX_W-1:0] last_dest;
        int                 pick;
        last_dest = '0;
        for (int i = 0; i < count; i++)
        begin
            // Every third block of a hundred runs with no sender gaps.
            quiet_phase = ((i / 100) % 3 == 2);

            if ($urandom_range(0, 99) < 8)
                op_code = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
                op_code = OP_W'($urandom_range(OP_AND, OP_ROR));

            dest = ($urandom_range(0, 99) < 35)
                 ? last_dest
                 : INDEX_W'($urandom_range(0, REG_COUNT - 1));
            pick = $urandom_range(0, 99);
            if (pick < 15)
                src = dest;
            else if (pick < 35)
                src = last_dest;
            else
                src = INDEX_W'($urandom_range(0, REG_COUNT - 1));

            send_instruction(op_code, dest, src, random_immediate());
            last_dest = dest;
        end
        quiet_phase = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening. The file is all zeros and the flags are clear.
        send_instruction(OP_AND,  5'd0,  5'd0,  BYTE_ZERO);     // zero result sets Z
        send_instruction(OP_ORI,  5'd1,  5'd0,  BYTE_ALL_ONES); // N and S from bit 7
        send_instruction(OP_ORI,  5'd31, 5'd0,  8'h80);         // top register
        send_instruction(OP_ANDI, 5'd1,  5'd0,  8'h0F);
        send_instruction(OP_OR,   5'd2,  5'd31, BYTE_ZERO);
        send_instruction(OP_EOR,  5'd2,  5'd1,  BYTE_ZERO);     // dependent on the last
        send_instruction(OP_EOR,  5'd1,  5'd1,  BYTE_ZERO);     // self-cancelling
        send_instruction(OP_COM,  5'd3,  5'd0,  BYTE_ZERO);     // carry forced high
        send_instruction(OP_ROR,  5'd31, 5'd0,  BYTE_ZERO);     // carry rotates into bit 7
        send_instruction(OP_OR,   5'd6,  5'd31, BYTE_ZERO);     // rotated value read back
        send_instruction(OP_ROR,  5'd4,  5'd0,  BYTE_ZERO);
        send_instruction(OP_LSR,  5'd2,  5'd0,  BYTE_ZERO);     // carry from old bit 0
        send_instruction(OP_ROR,  5'd2,  5'd0,  BYTE_ZERO);
        send_instruction(OP_SER,  5'd5,  5'd0,  BYTE_ZERO);     // flags must stay put
        send_instruction(OP_CLR,  5'd5,  5'd0,  BYTE_ZERO);     // carry survives a clear
        send_instruction(OP_UNUSED_HI, 5'd6, 5'd6, BYTE_ALL_ONES);
        send_instruction(OP_UNUSED_LO, 5'd0, 5'd31, BYTE_ALL_ONES);
        send_instruction(OP_OR,   5'd7,  5'd6,  BYTE_ZERO);     // unused code wrote nothing
        send_instruction(OP_ANDI, 5'd6,  5'd0,  BYTE_ZERO);     // bit clear to zero
        send_instruction(OP_LSR,  5'd3,  5'd0,  BYTE_ZERO);     // overflow from N xor C
        send_instruction(OP_ORI,  5'd0,  5'd0,  8'h01);
        send_instruction(OP_LSR,  5'd0,  5'd0,  BYTE_ZERO);     // shifts down to zero
        send_instruction(OP_AND,  5'd31, 5'd31, BYTE_ZERO);
        send_instruction(OP_ROR,  5'd3,  5'd0,  BYTE_ZERO);

        send_random_instructions(RANDOM_ITEMS);
        in_valid <= 1'b0;

        // Let every outstanding result arrive, then wait DRAIN_CYCLES more for
        // anything the unit should not have produced.
        while (result_board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (result_board.mismatches == 0)
            $display("logic_shift_unit_with_flags_top verification clean");
        else
            $display("logic_shift_unit_with_flags_top verification failed");
        $finish;
    end

endmodule
